[hdl/utxrf_pkg.sv]
package utxrf_pkg;

    // Register offsets from the base port.
    localparam logic [2:0] OFF_DATA  = 3'd0;
    localparam logic [2:0] OFF_IER   = 3'd1;
    localparam logic [2:0] OFF_IIR   = 3'd2;
    localparam logic [2:0] OFF_LCR   = 3'd3;
    localparam logic [2:0] OFF_MCR   = 3'd4;
    localparam logic [2:0] OFF_LSR   = 3'd5;
    localparam logic [2:0] OFF_MSR   = 3'd6;
    localparam logic [2:0] OFF_SCR   = 3'd7;

    // Bit positions and fixed read values.
    localparam int unsigned DLAB_POS  = 7;
    localparam int unsigned ETBEI_POS = 1;
    localparam logic [7:0] IIR_NONE  = 8'h01;
    localparam logic [7:0] IIR_THRE  = 8'h02;
    localparam logic [7:0] LSR_VALUE = 8'h60;
    localparam logic [7:0] MSR_VALUE = 8'hB0;

    // Configuration register indexes and reset values.
    localparam logic CFG_PORT_BASE    = 1'b0;
    localparam logic CFG_IRQ_ATTACHED = 1'b1;
    localparam logic [15:0] PORT_BASE_RESET = 16'd1016;
    localparam logic IRQ_ATTACHED_RESET     = 1'b1;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [15:0] port;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq_pulse;
        logic       first_tx;
    } rsp_t;

    typedef struct packed {
        logic [15:0] port_base;
        logic        irq_attached;
    } cfg_t;

endpackage

[hdl/uart_tx_only_register_file.sv]
// Transmit-only UART register file with a 16550-style register map.
// Request channel (req_valid/req_ready/req): one bus access per word, a read
// or write of one I/O port. Ports port_base through port_base+7 select the
// eight registers; the divisor latch bit in LCR banks offsets 0 and 1.
// Response channel (rsp_valid/rsp_ready/rsp): exactly one word per request,
// in order, carrying read data, the transmitted byte of a THR write, the
// transmit-empty interrupt pulse and the first-transmit flag.
// A request is registered in the request register on acceptance; its
// response is registered in the response register when that frees up. One
// request is accepted every cycle as long as responses are taken.
// When the receiver stalls, the response register holds its word and the
// request register holds one more; after that req_ready drops until
// rsp_ready returns.
// The APB port writes port_base (address 0) and irq_attached (address 4);
// the user must write it only while no access is in flight; the block does not enforce this.
// Reset clears all UART registers, the pending interrupt and the first
// transmit flag, and restores port_base to 1016 and irq_attached to 1.
module uart_tx_only_register_file
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                req_valid,
    output logic                req_ready,
    input  utxrf_pkg::req_t     req,

    output logic                rsp_valid,
    input  logic                rsp_ready,
    output utxrf_pkg::rsp_t     rsp,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    utxrf_pkg::cfg_t cfg_reg;
    utxrf_pkg::req_t req_reg;
    utxrf_pkg::rsp_t rsp_reg;
    utxrf_pkg::rsp_t core_rsp;
    logic            req_valid_reg;
    logic            rsp_valid_reg;
    logic            step;
    logic            cfg_write;

    // The held request is processed whenever the response register frees up.
    assign step      = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || step;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            utxrf_pkg::CFG_PORT_BASE:    prdata = {16'd0, cfg_reg.port_base};
            utxrf_pkg::CFG_IRQ_ATTACHED: prdata = {31'd0, cfg_reg.irq_attached};
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.port_base    <= utxrf_pkg::PORT_BASE_RESET;
            cfg_reg.irq_attached <= utxrf_pkg::IRQ_ATTACHED_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                utxrf_pkg::CFG_PORT_BASE:    cfg_reg.port_base    <= pwdata[15:0];
                utxrf_pkg::CFG_IRQ_ATTACHED: cfg_reg.irq_attached <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                req_valid_reg <= req_valid;
            end
            if (step)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            req_reg <= req;
        end
        if (step)
        begin
            rsp_reg <= core_rsp;
        end
    end

    utxrf_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .req   (req_reg),
        .cfg   (cfg_reg),
        .rsp   (core_rsp)
    );

`ifndef SYNTHESIS
    a_held_goes_out: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && !rsp_valid_reg |=> rsp_valid_reg)
        else $error("held request not moved to the response register");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !req_valid_reg |-> req_ready)
        else $error("request channel blocked while the pipeline is empty");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && rsp_valid_reg && !rsp_ready |=> req_valid_reg && rsp_valid_reg)
        else $error("held request lost during a response stall");
`endif

endmodule

[hdl/utxrf_core.sv]
module utxrf_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  utxrf_pkg::req_t     req,
    input  utxrf_pkg::cfg_t     cfg,
    output utxrf_pkg::rsp_t     rsp
);

    logic [7:0] ier_reg, ier_next;
    logic [7:0] lcr_reg, lcr_next;
    logic [7:0] mcr_reg, mcr_next;
    logic [7:0] scr_reg, scr_next;
    logic [7:0] fcr_reg, fcr_next;
    logic [7:0] dll_reg, dll_next;
    logic [7:0] dlm_reg, dlm_next;
    logic       pend_reg, pend_next;
    logic       first_reg, first_next;

    logic [15:0] offset;
    logic        in_range;
    logic        dlab;
    logic        thr_raise;
    logic        ier_raise;

    assign offset   = req.port - cfg.port_base;
    assign in_range = (offset[15:3] == 13'd0);
    assign dlab     = lcr_reg[utxrf_pkg::DLAB_POS];

    assign thr_raise = cfg.irq_attached && ier_reg[utxrf_pkg::ETBEI_POS] && !pend_reg;
    // The interrupt is only tried on a rising ETBEI.
    assign ier_raise = cfg.irq_attached && !ier_reg[utxrf_pkg::ETBEI_POS]
                       && req.write_data[utxrf_pkg::ETBEI_POS] && !pend_reg;

    always_comb
    begin
        ier_next   = ier_reg;
        lcr_next   = lcr_reg;
        mcr_next   = mcr_reg;
        scr_next   = scr_reg;
        fcr_next   = fcr_reg;
        dll_next   = dll_reg;
        dlm_next   = dlm_reg;
        pend_next  = pend_reg;
        first_next = first_reg;
        rsp        = '0;

        if (in_range)
        begin
            if (req.mode == utxrf_pkg::MODE_WRITE)
            begin
                unique case (offset[2:0])
                    utxrf_pkg::OFF_DATA:
                    begin
                        if (dlab)
                        begin
                            dll_next = req.write_data;
                        end
                        else
                        begin
                            first_next    = 1'b1;
                            rsp.first_tx  = !first_reg;
                            rsp.tx_valid  = 1'b1;
                            rsp.tx_byte   = req.write_data;
                            rsp.irq_pulse = thr_raise;
                            if (thr_raise)
                            begin
                                pend_next = 1'b1;
                            end
                        end
                    end
                    utxrf_pkg::OFF_IER:
                    begin
                        if (dlab)
                        begin
                            dlm_next = req.write_data;
                        end
                        else
                        begin
                            ier_next      = req.write_data;
                            rsp.irq_pulse = ier_raise;
                            if (ier_raise)
                            begin
                                pend_next = 1'b1;
                            end
                            else if (!req.write_data[utxrf_pkg::ETBEI_POS])
                            begin
                                pend_next = 1'b0;
                            end
                        end
                    end
                    utxrf_pkg::OFF_IIR: fcr_next = req.write_data;
                    utxrf_pkg::OFF_LCR: lcr_next = req.write_data;
                    utxrf_pkg::OFF_MCR: mcr_next = req.write_data;
                    utxrf_pkg::OFF_SCR: scr_next = req.write_data;
                    default: ;
                endcase
            end
            else
            begin
                unique case (offset[2:0])
                    utxrf_pkg::OFF_DATA: rsp.read_data = dlab ? dll_reg : 8'd0;
                    utxrf_pkg::OFF_IER:  rsp.read_data = dlab ? dlm_reg : ier_reg;
                    utxrf_pkg::OFF_IIR:
                    begin
                        // Reading IIR acknowledges the pending interrupt.
                        rsp.read_data = pend_reg ? utxrf_pkg::IIR_THRE : utxrf_pkg::IIR_NONE;
                        pend_next     = 1'b0;
                    end
                    utxrf_pkg::OFF_LCR:  rsp.read_data = lcr_reg;
                    utxrf_pkg::OFF_MCR:  rsp.read_data = mcr_reg;
                    utxrf_pkg::OFF_LSR:  rsp.read_data = utxrf_pkg::LSR_VALUE;
                    utxrf_pkg::OFF_MSR:  rsp.read_data = utxrf_pkg::MSR_VALUE;
                    utxrf_pkg::OFF_SCR:  rsp.read_data = scr_reg;
                    default:             rsp.read_data = 8'd0;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ier_reg   <= 8'd0;
            lcr_reg   <= 8'd0;
            mcr_reg   <= 8'd0;
            scr_reg   <= 8'd0;
            fcr_reg   <= 8'd0;
            dll_reg   <= 8'd0;
            dlm_reg   <= 8'd0;
            pend_reg  <= 1'b0;
            first_reg <= 1'b0;
        end
        else if (step)
        begin
            ier_reg   <= ier_next;
            lcr_reg   <= lcr_next;
            mcr_reg   <= mcr_next;
            scr_reg   <= scr_next;
            fcr_reg   <= fcr_next;
            dll_reg   <= dll_next;
            dlm_reg   <= dlm_next;
            pend_reg  <= pend_next;
            first_reg <= first_next;
        end
    end

`ifndef SYNTHESIS
    a_irq_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        step && rsp.irq_pulse |=> pend_reg)
        else $error("interrupt raised but not left pending");

    a_irq_needs_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && rsp.irq_pulse |-> !pend_reg && cfg.irq_attached)
        else $error("interrupt raised while one was pending or line detached");

    a_first_once: assert property (@(posedge clk) disable iff (!rst_n)
        step && rsp.first_tx |-> !first_reg ##1 first_reg)
        else $error("first transmit flag repeated");
`endif

endmodule
